// ===== hw/rtl/rcbp_pkg.sv =====
// Shared types and constants for the reference-counted buffer pool.
`timescale 1ns / 1ps
`default_nettype none

package rcbp_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int COUNT_BITS = 8;

    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int TOTAL_W    = $clog2(POOL_DEPTH + 1);
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int REPORT_W   = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ADDREF = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NOT_IN_USE = 2'd2,
        ST_SATURATED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   granted_slot;
        logic                released;
        logic [REPORT_W-1:0] in_use_count;
        logic [REPORT_W-1:0] peak_count;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcbp_in_reg.sv =====
// Input register: holds one command word until the pool engine takes it.
`timescale 1ns / 1ps
`default_nettype none

module rcbp_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rcbp_pkg::req_t s_req,
    output logic               req_valid,
    input  wire logic          req_take,
    output rcbp_pkg::req_t     req
);

    logic           valid_reg;
    logic           valid_next;
    rcbp_pkg::req_t req_reg;

    assign s_ready   = !valid_reg || req_take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (req_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rcbp_engine.sv =====
// Pool state and single-pass allocate, free and add-reference logic.
`timescale 1ns / 1ps
`default_nettype none

module rcbp_engine (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            commit,
    input  wire rcbp_pkg::req_t  req,
    output rcbp_pkg::result_t    result
);

    logic [rcbp_pkg::POOL_DEPTH-1:0] in_use_reg;
    logic [rcbp_pkg::POOL_DEPTH-1:0] in_use_next;
    logic [rcbp_pkg::COUNT_BITS-1:0] ref_count_reg  [rcbp_pkg::POOL_DEPTH];
    logic [rcbp_pkg::COUNT_BITS-1:0] ref_count_next [rcbp_pkg::POOL_DEPTH];
    logic [rcbp_pkg::TOTAL_W-1:0]    total_reg;
    logic [rcbp_pkg::TOTAL_W-1:0]    total_next;
    logic [rcbp_pkg::TOTAL_W-1:0]    peak_reg;
    logic [rcbp_pkg::TOTAL_W-1:0]    peak_next;

    logic                            found;
    logic [rcbp_pkg::IDX_W-1:0]      free_idx;
    logic [rcbp_pkg::IDX_W-1:0]      sidx;
    logic                            slot_ok;
    logic [rcbp_pkg::COUNT_BITS-1:0] cnt_cur;
    rcbp_pkg::status_t               status;
    logic [rcbp_pkg::SLOT_W-1:0]     granted;
    logic                            released;

    // lowest free slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = rcbp_pkg::POOL_DEPTH - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                found    = 1'b1;
                free_idx = rcbp_pkg::IDX_W'(i);
            end
        end
    end

    assign sidx    = rcbp_pkg::IDX_W'(req.slot);
    assign slot_ok = (int'(req.slot) < rcbp_pkg::POOL_DEPTH) && in_use_reg[sidx];
    assign cnt_cur = ref_count_reg[sidx];

    always_comb begin
        in_use_next    = in_use_reg;
        ref_count_next = ref_count_reg;
        total_next     = total_reg;
        status         = rcbp_pkg::ST_OK;
        granted        = '0;
        released       = 1'b0;
        case (rcbp_pkg::cmd_t'(req.cmd))
            rcbp_pkg::CMD_ALLOC: begin
                if (found) begin
                    in_use_next[free_idx]    = 1'b1;
                    ref_count_next[free_idx] = rcbp_pkg::COUNT_ONE;
                    total_next               = total_reg + 1'b1;
                    granted                  = rcbp_pkg::SLOT_W'(free_idx);
                end else begin
                    status = rcbp_pkg::ST_EXHAUSTED;
                end
            end
            rcbp_pkg::CMD_FREE: begin
                if (!slot_ok) begin
                    status = rcbp_pkg::ST_NOT_IN_USE;
                end else if (cnt_cur <= rcbp_pkg::COUNT_ONE) begin
                    ref_count_next[sidx] = '0;
                    in_use_next[sidx]    = 1'b0;
                    if (total_reg != '0) begin
                        total_next = total_reg - 1'b1;
                    end
                    released = 1'b1;
                end else begin
                    ref_count_next[sidx] = cnt_cur - 1'b1;
                end
            end
            rcbp_pkg::CMD_ADDREF: begin
                if (!slot_ok) begin
                    status = rcbp_pkg::ST_NOT_IN_USE;
                end else if (cnt_cur == rcbp_pkg::COUNT_MAX) begin
                    status = rcbp_pkg::ST_SATURATED;
                end else begin
                    ref_count_next[sidx] = cnt_cur + 1'b1;
                end
            end
            default: begin
            end
        endcase
        peak_next = (total_next > peak_reg) ? total_next : peak_reg;
    end

    assign result.status       = status;
    assign result.granted_slot = granted;
    assign result.released     = released;
    assign result.in_use_count = rcbp_pkg::REPORT_W'(total_next);
    assign result.peak_count   = rcbp_pkg::REPORT_W'(peak_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            total_reg  <= '0;
            peak_reg   <= '0;
            for (int i = 0; i < rcbp_pkg::POOL_DEPTH; i++) begin
                ref_count_reg[i] <= '0;
            end
        end else if (commit) begin
            in_use_reg    <= in_use_next;
            total_reg     <= total_next;
            peak_reg      <= peak_next;
            ref_count_reg <= ref_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rcbp_out_reg.sv =====
// Result register: holds one result word until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module rcbp_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              res_valid,
    output logic                   res_ready,
    input  wire rcbp_pkg::result_t res,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rcbp_pkg::result_t      m_res
);

    logic              valid_reg;
    logic              valid_next;
    rcbp_pkg::result_t res_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid && res_ready) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/refcounted_buffer_pool.sv =====
// Top level of the reference-counted buffer pool.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   command | s_valid s_ready s_cmd s_slot                 | in
//   result  | m_valid m_ready m_status m_granted_slot      | out
//           | m_released m_in_use_count m_peak_count       |
//
// One command per cycle with m_ready high; each result is registered.
// The lowest-free-slot encoder and one count update close in the engine cycle.
// Reset is synchronous and clears all slots and counters.
// With m_ready low the result holds and one more command can wait at the input.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_buffer_pool (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [rcbp_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [rcbp_pkg::SLOT_W-1:0]       s_slot,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [rcbp_pkg::STATUS_W-1:0]          m_status,
    output logic [rcbp_pkg::SLOT_W-1:0]            m_granted_slot,
    output logic                                   m_released,
    output logic [rcbp_pkg::REPORT_W-1:0]          m_in_use_count,
    output logic [rcbp_pkg::REPORT_W-1:0]          m_peak_count
);

    rcbp_pkg::req_t    s_req;
    rcbp_pkg::req_t    req;
    logic              req_valid;
    logic              res_ready;
    logic              commit;
    rcbp_pkg::result_t res;
    rcbp_pkg::result_t m_res;

    assign s_req.cmd  = s_cmd;
    assign s_req.slot = s_slot;
    assign commit     = req_valid && res_ready;

    rcbp_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .req_valid (req_valid),
        .req_take  (commit),
        .req       (req)
    );

    rcbp_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (commit),
        .req     (req),
        .result  (res)
    );

    rcbp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (req_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status       = m_res.status;
    assign m_granted_slot = m_res.granted_slot;
    assign m_released     = m_res.released;
    assign m_in_use_count = m_res.in_use_count;
    assign m_peak_count   = m_res.peak_count;

    a_peak_covers_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_peak_count >= m_in_use_count)
        else $error("peak count below in-use count");

    a_release_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_released) |-> m_status == rcbp_pkg::ST_OK)
        else $error("release reported with error status");

    a_grant_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_granted_slot != '0) |-> (m_status == rcbp_pkg::ST_OK && !m_released))
        else $error("grant reported with error status or release");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
